>>> rtl/oad_pkg.sv
// ----------------------------------------------------------------------------
// oad_pkg
// Shared types and constants of the object identifier arc decoder.
// ----------------------------------------------------------------------------
package oad_pkg;

    // default arc width
    localparam int ARC_BITS_DEFAULT = 32;

    // octet layout
    localparam int CONT_BIT   = 7;
    localparam int GROUP_BITS = 7;

    // split of the first subidentifier
    localparam int FIRST_DIV   = 40;
    localparam int FIRST_CLAMP = 2;

    // width of the arc field of a result
    localparam int ARC_OUT_BITS = 32;

    // queue between front and back, depth is a power of two
    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = PTR_W + 1;

    // status codes of a result
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_OVF   = 2'd1;
    localparam logic [1:0] STATUS_TRUNC = 2'd2;

    // what kind of record the front hands to the back
    typedef enum logic [1:0]
    {
        KIND_TRUNC,
        KIND_FIRST,
        KIND_NEXT
    } sub_kind_t;

    typedef struct packed
    {
        sub_kind_t kind;
        logic      ovf;
        logic      last;
    } sub_ctrl_t;

endpackage

>>> rtl/oad_if.sv
// ----------------------------------------------------------------------------
// oad_in_if / oad_out_if
// Valid/ready channels for content octets and decoded arcs.
// ----------------------------------------------------------------------------
interface oad_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] octet;
    logic       final_octet;

    modport source (output valid, output octet, output final_octet, input ready);
    modport sink (input valid, input octet, input final_octet, output ready);
endinterface

interface oad_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] arc;
    logic        last_arc;
    logic [1:0]  status;

    modport source (output valid, output arc, output last_arc, output status, input ready);
    modport sink (input valid, input arc, input last_arc, input status, output ready);
endinterface

>>> rtl/oad_front.sv
// ----------------------------------------------------------------------------
// oad_front
// Accumulates 7-bit groups and pushes one record per closed subidentifier or truncated identifier.
// ----------------------------------------------------------------------------
module oad_front
    import oad_pkg::*;
#(
    parameter int ARC_BITS = ARC_BITS_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    oad_in_if.sink              octets,
    input  logic                full,
    output logic                push,
    output sub_ctrl_t           push_ctrl,
    output logic [ARC_BITS-1:0] push_value
);

    logic [ARC_BITS-1:0] acc_reg;
    logic [ARC_BITS-1:0] acc_next;
    logic                ovf_reg;
    logic                ovf_next;
    logic                first_done_reg;
    logic                first_done_next;

    logic [ARC_BITS-1:0] acc_step;
    logic                ovf_step;
    logic                accept;
    logic                cont;

    assign octets.ready = !full;
    assign accept       = octets.valid && !full;
    assign cont         = octets.octet[CONT_BIT];

    // shift in one group, saturate once the top group is occupied
    always_comb
    begin
        acc_step = acc_reg;
        ovf_step = ovf_reg;
        if (!ovf_reg)
        begin
            if (acc_reg[ARC_BITS-1 -: GROUP_BITS] != '0)
            begin
                ovf_step = 1'b1;
                acc_step = '1;
            end
            else
            begin
                acc_step = {acc_reg[ARC_BITS-GROUP_BITS-1:0],
                            octets.octet[GROUP_BITS-1:0]};
            end
        end
    end

    // classify the octet and update state
    always_comb
    begin
        acc_next        = acc_reg;
        ovf_next        = ovf_reg;
        first_done_next = first_done_reg;
        push            = 1'b0;
        push_ctrl.kind  = KIND_NEXT;
        push_ctrl.ovf   = ovf_step;
        push_ctrl.last  = octets.final_octet;
        push_value      = acc_step;
        if (accept)
        begin
            if (cont && octets.final_octet)
            begin
                // identifier ends inside a subidentifier
                push            = 1'b1;
                push_ctrl.kind  = KIND_TRUNC;
                acc_next        = '0;
                ovf_next        = 1'b0;
                first_done_next = 1'b0;
            end
            else if (cont)
            begin
                acc_next = acc_step;
                ovf_next = ovf_step;
            end
            else
            begin
                push            = 1'b1;
                push_ctrl.kind  = first_done_reg ? KIND_NEXT : KIND_FIRST;
                acc_next        = '0;
                ovf_next        = 1'b0;
                first_done_next = !octets.final_octet;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg        <= '0;
            ovf_reg        <= 1'b0;
            first_done_reg <= 1'b0;
        end
        else
        begin
            acc_reg        <= acc_next;
            ovf_reg        <= ovf_next;
            first_done_reg <= first_done_next;
        end
    end

endmodule

>>> rtl/oad_queue.sv
// ----------------------------------------------------------------------------
// oad_queue
// Small FIFO of subidentifier records between front and back.
// ----------------------------------------------------------------------------
module oad_queue
    import oad_pkg::*;
#(
    parameter int ARC_BITS = ARC_BITS_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  sub_ctrl_t           push_ctrl,
    input  logic [ARC_BITS-1:0] push_value,
    input  logic                pop,
    output logic                full,
    output logic                head_valid,
    output sub_ctrl_t           head_ctrl,
    output logic [ARC_BITS-1:0] head_value
);

    sub_ctrl_t           ctrl_mem_reg  [QUEUE_DEPTH];
    logic [ARC_BITS-1:0] value_mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic                do_push;
    logic                do_pop;

    assign full       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_ctrl  = ctrl_mem_reg[rd_ptr_reg];
    assign head_value = value_mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = do_push ? PTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = CNT_W'(count_reg + 1'b1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = CNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage write
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            ctrl_mem_reg[wr_ptr_reg]  <= push_ctrl;
            value_mem_reg[wr_ptr_reg] <= push_value;
        end
    end

endmodule

>>> rtl/oad_back.sv
// ----------------------------------------------------------------------------
// oad_back
// Turns queued records into arc results through an output register.
// ----------------------------------------------------------------------------
module oad_back
    import oad_pkg::*;
#(
    parameter int ARC_BITS = ARC_BITS_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  sub_ctrl_t           head_ctrl,
    input  logic [ARC_BITS-1:0] head_value,
    output logic                pop,
    oad_out_if.source           arcs
);

    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic                    second_reg;
    logic                    second_next;
    logic [ARC_OUT_BITS-1:0] arc_reg;
    logic [ARC_OUT_BITS-1:0] arc_next;
    logic                    last_reg;
    logic                    last_next;
    logic [1:0]              status_reg;
    logic [1:0]              status_next;

    logic                    load;
    logic [1:0]              hi;
    logic [ARC_BITS-1:0]     lo;

    assign arcs.valid    = out_valid_reg;
    assign arcs.arc      = arc_reg;
    assign arcs.last_arc = last_reg;
    assign arcs.status   = status_reg;
    assign load          = !out_valid_reg || arcs.ready;

    // split of the first subidentifier into two arcs
    always_comb
    begin
        if (head_ctrl.ovf || head_value >= ARC_BITS'(2 * FIRST_DIV))
        begin
            hi = 2'(FIRST_CLAMP);
            lo = head_value - ARC_BITS'(2 * FIRST_DIV);
        end
        else if (head_value >= ARC_BITS'(FIRST_DIV))
        begin
            hi = 2'd1;
            lo = head_value - ARC_BITS'(FIRST_DIV);
        end
        else
        begin
            hi = 2'd0;
            lo = head_value;
        end
        if (head_ctrl.ovf)
        begin
            lo = '1;
        end
    end

    // result sequencing
    always_comb
    begin
        out_valid_next = out_valid_reg;
        second_next    = second_reg;
        arc_next       = arc_reg;
        last_next      = last_reg;
        status_next    = status_reg;
        pop            = 1'b0;
        if (load)
        begin
            out_valid_next = head_valid;
            if (head_valid)
            begin
                unique case (head_ctrl.kind)
                    KIND_TRUNC:
                    begin
                        arc_next    = '0;
                        last_next   = 1'b1;
                        status_next = STATUS_TRUNC;
                        pop         = 1'b1;
                    end
                    KIND_FIRST:
                    begin
                        if (!second_reg)
                        begin
                            arc_next    = ARC_OUT_BITS'(hi);
                            last_next   = 1'b0;
                            status_next = STATUS_OK;
                            second_next = 1'b1;
                        end
                        else
                        begin
                            arc_next    = ARC_OUT_BITS'(lo);
                            last_next   = head_ctrl.last;
                            status_next = head_ctrl.ovf ? STATUS_OVF : STATUS_OK;
                            second_next = 1'b0;
                            pop         = 1'b1;
                        end
                    end
                    default:
                    begin
                        arc_next    = ARC_OUT_BITS'(head_value);
                        last_next   = head_ctrl.last;
                        status_next = head_ctrl.ovf ? STATUS_OVF : STATUS_OK;
                        pop         = 1'b1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            second_reg    <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            second_reg    <= second_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        arc_reg    <= arc_next;
        last_reg   <= last_next;
        status_reg <= status_next;
    end

endmodule

>>> rtl/oid_arc_decoder.sv
// ----------------------------------------------------------------------------
// oid_arc_decoder
// Decoder of BER object identifier content octets into arcs.
// ----------------------------------------------------------------------------
// Takes content octets on octets and delivers arcs on arcs. The front
// accumulates each subidentifier with a single shift-in per octet, so the
// input side sustains one octet per clock while the queue is not full.
// Closed subidentifiers go into a four-entry queue; the back drains it
// through an output register, one arc per clock while arcs is ready. The
// first subidentifier of an identifier yields two arcs and is popped after
// the second. A closing octet's record goes to the queue storage, then to
// the output register. Arcs wider than ARC_BITS saturate with status 1; an
// identifier ending inside a subidentifier gives one arc 0 with status 2.
module oid_arc_decoder
    import oad_pkg::*;
#(
    parameter int ARC_BITS = ARC_BITS_DEFAULT
)
(
    input  logic      clk,
    input  logic      rst_n,
    oad_in_if.sink    octets,
    oad_out_if.source arcs
);

    logic                push;
    sub_ctrl_t           push_ctrl;
    logic [ARC_BITS-1:0] push_value;
    logic                pop;
    logic                full;
    logic                head_valid;
    sub_ctrl_t           head_ctrl;
    logic [ARC_BITS-1:0] head_value;

    // octet accumulation and classification
    oad_front #(.ARC_BITS(ARC_BITS)) u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .octets     (octets),
        .full       (full),
        .push       (push),
        .push_ctrl  (push_ctrl),
        .push_value (push_value)
    );

    // record queue
    oad_queue #(.ARC_BITS(ARC_BITS)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_ctrl  (push_ctrl),
        .push_value (push_value),
        .pop        (pop),
        .full       (full),
        .head_valid (head_valid),
        .head_ctrl  (head_ctrl),
        .head_value (head_value)
    );

    // arc generation
    oad_back #(.ARC_BITS(ARC_BITS)) u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_ctrl  (head_ctrl),
        .head_value (head_value),
        .pop        (pop),
        .arcs       (arcs)
    );

endmodule

>>> tb/tb_oid_arc_decoder.sv
// ----------------------------------------------------------------------------
// tb_oid_arc_decoder
// Self-checking bench for the object identifier arc decoder.
// ----------------------------------------------------------------------------
// Feeds content octets into the decoder and predicts the arcs that each
// octet should produce. Each arc is compared field by field with the
// oldest prediction. A directed run covers:
//   - a well-known identifier
//   - the split point at 80 of the first subidentifier
//   - non-minimal leading groups
//   - the largest arc that still fits
//   - saturation of first and later arcs
//   - truncation
// After that, random identifiers are mixed with noise octets. Both the
// octet and the arc channels idle at random, with a stretch that has no
// idling at all.
// ----------------------------------------------------------------------------
module tb_oid_arc_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    import oad_pkg::*;

    localparam int ARC_BITS      = ARC_BITS_DEFAULT;
    localparam int RANDOM_OCTETS = 900;

    typedef struct
    {
        logic [ARC_OUT_BITS-1:0] arc;
        logic                    last_arc;
        logic [1:0]              status;
    } arc_result_t;

    // predicts the arcs of an octet stream and checks arrivals against them
    class oid_arc_model;
        logic [63:0] acc;
        logic        ovf_seen;
        logic        first_done;
        logic [63:0] arc_max;
        arc_result_t pending_arcs[$];
        int          failures;

        function new();
            arc_max    = ((64'd1 << (ARC_BITS - 1)) << 1) - 64'd1;
            acc        = '0;
            ovf_seen   = 1'b0;
            first_done = 1'b0;
            failures   = 0;
        endfunction

        function void push_arc(logic [63:0] value, logic last, logic [1:0] status);
            arc_result_t r;
            r.arc      = value[ARC_OUT_BITS-1:0];
            r.last_arc = last;
            r.status   = status;
            pending_arcs.push_back(r);
        endfunction

        // note one accepted octet and queue the arcs it closes
        function void take_octet(logic [7:0] octet, logic fin);
            logic        cont;
            logic [63:0] hi;
            logic [63:0] lo;
            cont = octet[CONT_BIT];

            // shift the group in unless the subidentifier is already saturated
            if (!ovf_seen)
            begin
                if ((acc >> (ARC_BITS - GROUP_BITS)) != 0)
                begin
                    ovf_seen = 1'b1;
                    acc      = arc_max;
                end
                else
                begin
                    acc = ((acc << GROUP_BITS) | octet[GROUP_BITS-1:0]) & arc_max;
                end
            end

            // continuation octet, truncated identifier if it is the last one
            if (cont)
            begin
                if (fin)
                begin
                    push_arc(64'd0, 1'b1, STATUS_TRUNC);
                    acc        = '0;
                    ovf_seen   = 1'b0;
                    first_done = 1'b0;
                end
                return;
            end

            // first subidentifier splits into two arcs
            if (!first_done)
            begin
                if (ovf_seen)
                begin
                    push_arc(FIRST_CLAMP, 1'b0, STATUS_OK);
                    push_arc(arc_max, fin, STATUS_OVF);
                end
                else
                begin
                    hi = acc / FIRST_DIV;
                    if (hi > FIRST_CLAMP)
                        hi = FIRST_CLAMP;
                    lo = acc - hi * FIRST_DIV;
                    push_arc(hi, 1'b0, STATUS_OK);
                    push_arc(lo, fin, STATUS_OK);
                end
                first_done = 1'b1;
            end
            else
            begin
                push_arc(acc, fin, ovf_seen ? STATUS_OVF : STATUS_OK);
            end

            acc      = '0;
            ovf_seen = 1'b0;
            if (fin)
                first_done = 1'b0;
        endfunction

        // compare one delivered arc with the oldest prediction
        function void check_arc(logic [ARC_OUT_BITS-1:0] arc, logic last_arc,
                                logic [1:0] status);
            arc_result_t r;
            if (pending_arcs.size() == 0)
            begin
                $error("unexpected arc: arc %0d last_arc %0d status %0d",
                       arc, last_arc, status);
                failures++;
                return;
            end
            r = pending_arcs.pop_front();
            if (arc !== r.arc)
            begin
                $error("arc: expected %0d, got %0d", r.arc, arc);
                failures++;
            end
            if (last_arc !== r.last_arc)
            begin
                $error("last_arc: expected %0d, got %0d", r.last_arc, last_arc);
                failures++;
            end
            if (status !== r.status)
            begin
                $error("status: expected %0d, got %0d", r.status, status);
                failures++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    bit   steady;
    int   sent;

    oid_arc_model model;

    oad_in_if  octets_if ();
    oad_out_if arcs_if ();

    oid_arc_decoder #(.ARC_BITS(ARC_BITS)) uut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .octets(octets_if),
        .arcs  (arcs_if)
    );

    // clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // arc channel back-pressure
    always @(posedge clk)
    begin
        if (!rst_n)
            arcs_if.ready <= 1'b0;
        else
            arcs_if.ready <= steady || ($urandom_range(99) >= 28);
    end

    // observe transfers on both channels
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (octets_if.valid && octets_if.ready)
                model.take_octet(octets_if.octet, octets_if.final_octet);
            if (arcs_if.valid && arcs_if.ready)
                model.check_arc(arcs_if.arc, arcs_if.last_arc, arcs_if.status);
        end
    end

    // present one octet, with a random gap before it, and wait for its transfer
    task automatic send_octet(input logic [7:0] octet, input logic fin);
        if (!steady && $urandom_range(99) < 20)
        begin
            octets_if.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        octets_if.valid       <= 1'b1;
        octets_if.octet       <= octet;
        octets_if.final_octet <= fin;
        do
            @(posedge clk);
        while (!octets_if.ready);
        sent++;
    endtask

    // hold the octet channel until every predicted arc has arrived
    task automatic wait_for_drain();
        octets_if.valid <= 1'b0;
        // let the last octet transfer reach the model first
        @(posedge clk);
        while (model.pending_arcs.size() != 0)
            @(posedge clk);
    endtask

    // one well-formed identifier with random groups, sometimes cut short
    task automatic send_random_oid();
        int   n_sub;
        int   n_grp;
        int   pick;
        bit   trunc;
        logic cont;
        logic fin;
        n_sub = $urandom_range(1, 6);
        trunc = ($urandom_range(99) < 10);
        for (int s = 0; s < n_sub; s++)
        begin
            pick = $urandom_range(99);
            if (pick < 60)
                n_grp = 1;
            else if (pick < 85)
                n_grp = $urandom_range(2, 3);
            else if (pick < 95)
                n_grp = 4;
            else
                n_grp = $urandom_range(5, 6);
            for (int g = 0; g < n_grp; g++)
            begin
                fin  = (s == n_sub - 1) && (g == n_grp - 1);
                cont = (g != n_grp - 1) || (fin && trunc);
                send_octet({cont, 7'($urandom_range(127))}, fin);
            end
        end
    endtask

    // stimulus
    initial
    begin
        model  = new();
        steady = 1'b0;
        sent   = 0;
        rst_n  <= 1'b0;
        octets_if.valid       <= 1'b0;
        octets_if.octet       <= 8'h00;
        octets_if.final_octet <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // 1.2.840.113549
        send_octet(8'h2a, 1'b0);
        send_octet(8'h86, 1'b0);
        send_octet(8'h48, 1'b0);
        send_octet(8'h86, 1'b0);
        send_octet(8'hf7, 1'b0);
        send_octet(8'h0d, 1'b1);

        // first subidentifier at zero and around the split point at 80
        send_octet(8'h00, 1'b1);
        send_octet(8'h4f, 1'b1);
        send_octet(8'h50, 1'b1);
        send_octet(8'h7f, 1'b1);

        // leading empty group, then the largest arc that still fits
        send_octet(8'h80, 1'b0);
        send_octet(8'h05, 1'b0);
        send_octet(8'h8f, 1'b0);
        send_octet(8'hff, 1'b0);
        send_octet(8'hff, 1'b0);
        send_octet(8'hff, 1'b0);
        send_octet(8'h7f, 1'b1);

        // saturated first subidentifier
        repeat (5) send_octet(8'hff, 1'b0);
        send_octet(8'h7f, 1'b0);
        // saturated later subidentifier
        send_octet(8'h90, 1'b0);
        repeat (3) send_octet(8'h80, 1'b0);
        send_octet(8'h00, 1'b0);
        // identifier cut short inside a subidentifier
        send_octet(8'hff, 1'b1);

        wait_for_drain();

        // random identifiers mixed with noise octets
        sent = 0;
        while (sent < RANDOM_OCTETS)
        begin
            steady = (sent >= 300) && (sent < 450);
            if ($urandom_range(99) < 85)
                send_random_oid();
            else
                repeat ($urandom_range(1, 4))
                    send_octet(8'($urandom_range(255)), $urandom_range(99) < 30);
            if (!steady && $urandom_range(99) < 3)
                wait_for_drain();
        end
        steady = 1'b0;

        wait_for_drain();
        repeat (8) @(posedge clk);
        if (model.failures == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // watchdog
    initial
    begin
        #400000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

>>> files.f
rtl/oad_pkg.sv
rtl/oad_if.sv
rtl/oad_front.sv
rtl/oad_queue.sv
rtl/oad_back.sv
rtl/oid_arc_decoder.sv
tb/tb_oid_arc_decoder.sv
